// ===== hw/rtl/dual_policy_service_queue_top_defines.svh =====
// assertion macros for the service queue checker
`ifndef DUAL_POLICY_SERVICE_QUEUE_TOP_DEFINES_SVH
`define DUAL_POLICY_SERVICE_QUEUE_TOP_DEFINES_SVH
// implication checked on every edge outside reset
`define DPSQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define DPSQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/dpsq_pkg.sv =====
// shared types and codes for the service queue
package dpsq_pkg;
  localparam int IdW     = 11;
  localparam int AmountW = 20;

  localparam logic [1:0] OpArrive  = 2'd0;
  localparam logic [1:0] OpOldest  = 2'd1;
  localparam logic [1:0] OpRichest = 2'd2;

  localparam logic [1:0] StServed   = 2'd0;
  localparam logic [1:0] StAccepted = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [AmountW-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] customer_id;
    logic [1:0]     status;
  } rsp_t;
endpackage

// ===== hw/rtl/dual_policy_service_queue_top.sv =====
// service queue top level: amount and served-mark memories with a scan sequencer
// arrive and empty/full answers go through SResp to the registered strobe; next start in strobe cycle
// serve oldest steps SIssue/SEval over ids from the oldest pointer, skipping served entries, then SMark, SResp
// serve richest steps SIssue/SEval over every id from oldest_pointer to next_id, then SMark, SResp
// after reset a clearing pass sweeps all MAX_CUSTOMERS served marks,
// busy_o stays high meanwhile; the strobe is one cycle wide and cannot be stalled
module dual_policy_service_queue_top #(
  parameter int MAX_CUSTOMERS = 1024,
  parameter int AMOUNT_BITS   = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  dpsq_pkg::req_t req_i,
  output logic           busy_o,
  output logic           valid_o,
  output dpsq_pkg::rsp_t rsp_o
);
  import dpsq_pkg::*;

  localparam int SlotW = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
  localparam int CntW  = $clog2(MAX_CUSTOMERS + 2);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SIssue = 3'd2;
  localparam logic [2:0] SEval  = 3'd3;
  localparam logic [2:0] SMark  = 3'd4;
  localparam logic [2:0] SResp  = 3'd5;

  logic [AMOUNT_BITS-1:0] amt_mem [MAX_CUSTOMERS];
  logic                   mark_mem [MAX_CUSTOMERS];

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        next_id_q, next_id_d, oldest_q, oldest_d, wait_q, wait_d;
  logic [CntW-1:0]        scan_q, scan_d, best_q, best_d;
  logic [AMOUNT_BITS-1:0] best_amt_q, best_amt_d;
  logic                   found_q, found_d, richest_q, richest_d;
  logic [SlotW-1:0]       clr_q, clr_d;
  rsp_t                   rsp_q, rsp_d;
  logic                   valid_q, valid_d;

  logic                   rd_en, mk_we, am_we, mk_val;
  logic [SlotW-1:0]       rd_slot, wr_slot;
  logic [AMOUNT_BITS-1:0] rd_amt, wr_amt;
  logic                   rd_mark;

  logic [CntW-1:0] one_c;
  assign one_c = CntW'(1);

  function automatic logic [SlotW-1:0] slot_of(input logic [CntW-1:0] id);
    logic [CntW-1:0] t;
    t = id - CntW'(1);
    return t[SlotW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (am_we) amt_mem[wr_slot] <= wr_amt;
    if (mk_we) mark_mem[wr_slot] <= mk_val;
    if (rd_en) begin
      rd_amt  <= amt_mem[rd_slot];
      rd_mark <= mark_mem[rd_slot];
    end
  end

  always_comb begin
    state_d = state_q; next_id_d = next_id_q; oldest_d = oldest_q; wait_d = wait_q;
    scan_d = scan_q; best_d = best_q; best_amt_d = best_amt_q; found_d = found_q;
    richest_d = richest_q; clr_d = clr_q; rsp_d = rsp_q; valid_d = 1'b0;
    rd_en = 1'b0; rd_slot = slot_of(scan_q);
    mk_we = 1'b0; am_we = 1'b0; mk_val = 1'b0; wr_slot = clr_q;
    wr_amt = AMOUNT_BITS'(req_i.amount);
    case (state_q)
      SClear: begin
        mk_we = 1'b1;
        clr_d = clr_q + SlotW'(1);
        if (clr_q == SlotW'(MAX_CUSTOMERS - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          if (req_i.operation == OpArrive) begin
            state_d = SResp;
            if (next_id_q >= CntW'(MAX_CUSTOMERS)) begin
              rsp_d = '{customer_id: '0, status: StFull};
            end else begin
              next_id_d = next_id_q + one_c;
              wr_slot = slot_of(next_id_q + one_c);
              am_we = 1'b1; mk_we = 1'b1;
              wait_d = wait_q + one_c;
              rsp_d = '{customer_id: IdW'(next_id_q + one_c), status: StAccepted};
            end
          end else if (req_i.operation == OpOldest || req_i.operation == OpRichest) begin
            if (wait_q == '0) begin
              state_d = SResp;
              rsp_d = '{customer_id: '0, status: StEmpty};
            end else begin
              state_d = SIssue;
              richest_d = (req_i.operation == OpRichest);
              scan_d = oldest_q; found_d = 1'b0; best_d = '0; best_amt_d = '0;
            end
          end
        end
      end
      SIssue: begin
        // scan end reached
        if (scan_q > next_id_q) begin
          if (found_q) state_d = SMark;
          else begin
            rsp_d = '{customer_id: '0, status: StEmpty};
            state_d = SResp;
          end
        end else begin
          rd_en = 1'b1;
          state_d = SEval;
        end
      end
      SEval: begin
        state_d = SIssue;
        scan_d = scan_q + one_c;
        if (!rd_mark) begin
          if (!richest_q) begin
            oldest_d = scan_q; best_d = scan_q; found_d = 1'b1;
            state_d = SMark;
          end else if (!found_q || rd_amt > best_amt_q) begin
            best_d = scan_q; best_amt_d = rd_amt; found_d = 1'b1;
          end
        end else if (!richest_q) begin
          oldest_d = scan_q + one_c;
        end
      end
      SMark: begin
        mk_we = 1'b1; mk_val = 1'b1; wr_slot = slot_of(best_q);
        wait_d = wait_q - one_c;
        if (best_q == oldest_q) oldest_d = best_q + one_c;
        rsp_d = '{customer_id: IdW'(best_q), status: StServed};
        state_d = SResp;
      end
      SResp: begin
        valid_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; next_id_q <= '0; oldest_q <= CntW'(1); wait_q <= '0;
      clr_q <= '0; valid_q <= 1'b0; scan_q <= '0; found_q <= 1'b0; richest_q <= 1'b0;
    end else begin
      state_q <= state_d; next_id_q <= next_id_d; oldest_q <= oldest_d; wait_q <= wait_d;
      clr_q <= clr_d; valid_q <= valid_d; scan_q <= scan_d; found_q <= found_d;
      richest_q <= richest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; best_amt_q <= best_amt_d; rsp_q <= rsp_d;
  end

  assign busy_o  = (state_q != SIdle);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;
endmodule

// ===== hw/rtl/dpsq_checker.sv =====
// port-level checker for the service queue, bound to the top level
`include "dual_policy_service_queue_top_defines.svh"
module dpsq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input dpsq_pkg::req_t req_i,
  input logic           busy_o,
  input logic           valid_o,
  input dpsq_pkg::rsp_t rsp_o
);
  import dpsq_pkg::*;
  // a real operation keeps the block busy in the next cycle
  `DPSQ_ASSERT_NXT(acc_busy, clk_i, rst_ni,
    start_i && !busy_o && (req_i.operation == OpArrive || req_i.operation == OpOldest ||
    req_i.operation == OpRichest), busy_o)
  // strobe is one cycle wide
  `DPSQ_ASSERT_NXT(one_strobe, clk_i, rst_ni, valid_o, !valid_o)
  // a strobe ends the busy period
  `DPSQ_ASSERT_IMP(strobe_idle, clk_i, rst_ni, valid_o, !busy_o)
  // a nonzero id only with served or accepted status
  `DPSQ_ASSERT_IMP(id_status, clk_i, rst_ni,
    valid_o && rsp_o.customer_id != '0, rsp_o.status == StServed || rsp_o.status == StAccepted)
endmodule

bind dual_policy_service_queue_top dpsq_checker u_dpsq_checker (.*);
